@@ rtl/core/tdd_pkg.sv @@
// ----------------------------------------------------------------------------
// tdd_pkg
// Shared constants and types for the tile dictionary deduplication block.
// ----------------------------------------------------------------------------
package tdd_pkg;

  localparam int MAX_TILES = 768;
  localparam int TILE_ROWS = 8;
  localparam int TILE_COLS = 8;

  localparam int PIX_W  = 64;
  localparam int IDX_W  = 10;
  localparam int OFS_W  = 8;
  localparam int ROW_W  = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int ADDR_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  localparam logic [OFS_W-1:0] DEFAULT_INDEX_OFFSET = 8'h18;

  localparam logic [PIX_W-1:0] ROW_MASK =
    (TILE_COLS >= 8) ? {PIX_W{1'b1}} : ((64'd1 << (8 * TILE_COLS)) - 64'd1);

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
  } tdd_hit_t;

endpackage

@@ rtl/core/tdd_lane.sv @@
// ----------------------------------------------------------------------------
// tdd_lane
// One row lane: holds the current tile's row, stores that row of every
// dictionary tile and compares a stored row against the held one.
// ----------------------------------------------------------------------------
module tdd_lane (
  input  logic                       clk,
  input  logic                       row_clear,
  input  logic                       row_load,
  input  logic [tdd_pkg::PIX_W-1:0]  row_data,
  input  logic                       mem_we,
  input  logic [tdd_pkg::ADDR_W-1:0] mem_waddr,
  input  logic                       rd_en,
  input  logic [tdd_pkg::ADDR_W-1:0] rd_addr,
  output logic                       match
);
  import tdd_pkg::*;

  logic [PIX_W-1:0] mem [MAX_TILES];
  logic [PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] row_reg;

  always_ff @(posedge clk) begin
    if (row_load) begin
      row_reg <= row_data;
    end else if (row_clear) begin
      row_reg <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= row_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign match = (rd_data == row_reg);

endmodule

@@ rtl/core/tdd_merge.sv @@
// ----------------------------------------------------------------------------
// tdd_merge
// Combines the lane compares into a whole-tile hit for the tile under test.
// ----------------------------------------------------------------------------
module tdd_merge (
  input  logic [tdd_pkg::TILE_ROWS-1:0] lane_match,
  input  logic                          rd_valid,
  input  logic [tdd_pkg::IDX_W-1:0]     rd_idx,
  output tdd_pkg::tdd_hit_t             result
);
  import tdd_pkg::*;

  always_comb begin
    result.hit   = rd_valid & (&lane_match);
    result.index = rd_idx;
  end

endmodule

@@ rtl/core/tile_dictionary_dedup.sv @@
// Rows are taken one per cycle while idle (in_stall low); the closing row starts a scan
// of at most tile_count stored tiles (one stored tile per cycle through the lane memories'
// read port), then the FINISH state stores a new tile and registers the result once the
// output is free. One tile is worked on at a time. Reset clears control state and
// empties the dictionary; index_offset returns to 24; no clearing pass.
// ----------------------------------------------------------------------------
// tile_dictionary_dedup
// Tile deduplication against a per-frame dictionary, row lanes in parallel.
// ----------------------------------------------------------------------------
module tile_dictionary_dedup (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [tdd_pkg::OFS_W-1:0] cfg_write_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [tdd_pkg::PIX_W-1:0] row_pixels,
  input  logic                      first_of_frame,
  input  logic                      last_row,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tdd_pkg::IDX_W-1:0] tile_index,
  output logic [tdd_pkg::IDX_W-1:0] map_entry,
  output logic                      is_new,
  output logic                      dict_full
);
  import tdd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state;
  logic [ROW_W-1:0] row_position;
  logic [IDX_W-1:0] tile_count;
  logic [IDX_W-1:0] issue_addr;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             res_hit;
  logic [IDX_W-1:0] res_idx;
  logic [OFS_W-1:0] index_offset;

  logic                 accept;
  logic                 tile_done;
  logic                 issue;
  logic                 out_free;
  logic                 store_new;
  logic                 is_full;
  logic [PIX_W-1:0]     row_masked;
  logic [TILE_ROWS-1:0] lane_match;
  tdd_hit_t             merged;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid & ~in_stall;
  assign tile_done  = last_row | (row_position == ROW_W'(TILE_ROWS - 1));
  assign row_masked = row_pixels & ROW_MASK;
  assign issue      = (state == ST_SCAN) && (issue_addr < tile_count) && !merged.hit;
  assign out_free   = ~out_valid | ~out_stall;
  assign is_full    = (tile_count == IDX_W'(MAX_TILES));
  assign store_new  = (state == ST_FINISH) && out_free && !res_hit && !is_full;

  for (genvar g = 0; g < TILE_ROWS; g++) begin : g_lane
    tdd_lane u_lane (
      .clk       (clk),
      .row_clear (accept && (row_position == '0)),
      .row_load  (accept && (row_position == ROW_W'(g))),
      .row_data  (row_masked),
      .mem_we    (store_new),
      .mem_waddr (tile_count[ADDR_W-1:0]),
      .rd_en     (issue),
      .rd_addr   (issue_addr[ADDR_W-1:0]),
      .match     (lane_match[g])
    );
  end

  tdd_merge u_merge (
    .lane_match (lane_match),
    .rd_valid   (rd_valid),
    .rd_idx     (rd_idx),
    .result     (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      index_offset <= DEFAULT_INDEX_OFFSET;
    end else if (cfg_write_en) begin
      index_offset <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      row_position <= '0;
      tile_count   <= '0;
      issue_addr   <= '0;
      rd_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if ((row_position == '0) && first_of_frame) begin
              tile_count <= '0;
            end
            if (tile_done) begin
              row_position <= '0;
              issue_addr   <= '0;
              rd_valid     <= 1'b0;
              state        <= ST_SCAN;
            end else begin
              row_position <= row_position + ROW_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (merged.hit) begin
            res_hit  <= 1'b1;
            res_idx  <= merged.index;
            rd_valid <= 1'b0;
            state    <= ST_FINISH;
          end else if (!issue && !rd_valid) begin
            res_hit <= 1'b0;
            state   <= ST_FINISH;
          end else begin
            rd_valid <= issue;
            rd_idx   <= issue_addr;
            if (issue) begin
              issue_addr <= issue_addr + IDX_W'(1);
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            if (res_hit) begin
              tile_index <= res_idx;
              map_entry  <= res_idx + IDX_W'(index_offset);
              is_new     <= 1'b0;
              dict_full  <= 1'b0;
            end else if (is_full) begin
              tile_index <= '0;
              map_entry  <= '0;
              is_new     <= 1'b0;
              dict_full  <= 1'b1;
            end else begin
              tile_index <= tile_count;
              map_entry  <= tile_count + IDX_W'(index_offset);
              is_new     <= 1'b1;
              dict_full  <= 1'b0;
              tile_count <= tile_count + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
